/* rtl/pett_pkg.sv */
// Package for the priority evicting timed table: constants, modes, config indexes.
package pett_pkg;
    localparam int DEPTH_DEF = 16;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_ADD    = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;
    localparam logic [1:0] MODE_QUERY  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_AGING = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ENTRIES  = 1'd1;
endpackage

/* rtl/priority_evicting_timed_table_core.sv */
// Top level of the priority evicting timed table core.
// Flow: an accepted word runs scan, compact and stats passes through one read
//   port and comparator, plus decide and append; the compact pass reads nothing
//   when nothing is rewritten.
// One word at a time: o_stall stays high until the result word has been taken
//   past i_stall.
// Reset (synchronous, active low): table empty, id counter and totals zero,
//   aging on, limit 16. Table storage itself is not cleared.
module priority_evicting_timed_table_core #(
    parameter int TABLE_DEPTH = pett_pkg::DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_delta_ms,
    input  logic [7:0]  i_category,
    input  logic [15:0] i_duration_ms,
    input  logic [7:0]  i_priority_req,
    input  logic [15:0] i_target_id,
    input  logic        i_cfg_we,
    input  logic [pett_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pett_pkg::CFG_W-1:0]     i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_status,
    output logic [15:0] o_new_id,
    output logic [4:0]  o_entry_count,
    output logic [4:0]  o_category_count,
    output logic        o_has_entries,
    output logic [7:0]  o_top_priority,
    output logic [31:0] o_added_total,
    output logic [31:0] o_expired_total
);
    import pett_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int LW = (CW > 5) ? CW : 5;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    // One-hot sequencer. Passes: SCAN finds the eviction victim or remove target,
    // COMPACT reads each entry once and writes survivors down (ages for tick,
    // skips one dropped slot otherwise), APPEND writes the new entry, STATS
    // walks the table for the category count and top priority.
    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_SCAN    = 7'b0000010,
        S_DECIDE  = 7'b0000100,
        S_COMPACT = 7'b0001000,
        S_APPEND  = 7'b0010000,
        S_STATS   = 7'b0100000,
        S_OUT     = 7'b1000000
    } t_state;

    // Table word in the single memory.
    typedef struct packed {
        logic [15:0] ident;
        logic [7:0]  cat;
        logic [7:0]  prio;
        logic [15:0] rem;
    } t_entry;

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd;            // registered read word
    logic   r_rd_ok;         // r_rd holds entry r_rd_idx
    logic [AW-1:0] r_rd_idx;

    t_state r_state, n_state;
    logic        r_aging;
    logic [4:0]  r_max;
    logic [CW-1:0] r_fill, r_wr;
    logic [CW-1:0] r_ptr;    // read pointer within a pass
    logic [15:0] r_next_id;
    logic [31:0] r_added, r_expired;

    // item latch
    logic [1:0]  r_mode;
    logic [15:0] r_delta, r_dur, r_target;
    logic [7:0]  r_cat, r_preq;

    // scan results
    logic        r_found;
    logic [AW-1:0] r_best;
    logic [7:0]  r_low;
    logic        r_drop;     // compact drops slot r_best

    // result
    logic        r_status;
    logic [15:0] r_nid;
    logic [4:0]  r_ccnt;
    logic [7:0]  r_top;
    logic        r_oval;

    logic [CW-1:0] limit;
    assign limit = (LW'(r_max) > LW'(TABLE_DEPTH)) ? DEPTH_C : CW'(r_max);

    logic at_end;   // read pointer past last held entry
    assign at_end = (r_ptr >= r_fill);

    // read stage shared by all passes: one address a cycle
    always_ff @(posedge i_clk) begin
        r_rd     <= r_mem[r_ptr[AW-1:0]];
        r_rd_idx <= r_ptr[AW-1:0];
    end

    logic pass_rd;
    assign pass_rd = (r_state == S_SCAN) || (r_state == S_COMPACT) || (r_state == S_STATS);

    // shared compare unit on the registered word
    logic scan_hit, expire;
    always_comb begin
        if (r_mode == MODE_ADD)
            scan_hit = (r_rd.prio < r_low) || ((r_rd.prio == r_low) && !r_found);
        else
            scan_hit = !r_found && (r_rd.ident == r_target);
        expire = (r_mode == MODE_TICK) && (r_rd.rem <= r_delta);
    end

    logic mem_we;
    logic [AW-1:0] mem_wa;
    t_entry mem_wd;
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_wr[AW-1:0];
        mem_wd = r_rd;
        if (r_state == S_COMPACT && r_rd_ok) begin
            if (r_mode == MODE_TICK) begin
                mem_we = !expire;
                mem_wd.rem = r_rd.rem - r_delta;
            end else begin
                mem_we = !(r_drop && r_rd_idx == r_best);
            end
        end else if (r_state == S_APPEND) begin
            // APPEND writes only when the add goes through
            mem_we = (r_mode == MODE_ADD) && !r_status && (r_fill < DEPTH_C);
            mem_wa = r_fill[AW-1:0];
            mem_wd = '{ident: r_next_id, cat: r_cat, prio: r_preq, rem: r_dur};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we)
            r_mem[mem_wa] <= mem_wd;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (i_valid) begin
                n_state = S_SCAN;
            end
            S_SCAN:    if (at_end && !r_rd_ok) begin
                n_state = S_DECIDE;
            end
            S_DECIDE:  n_state = S_COMPACT;
            S_COMPACT: if (at_end && !r_rd_ok) begin
                n_state = S_APPEND;
            end
            S_APPEND:  n_state = S_STATS;
            S_STATS:   if (at_end && !r_rd_ok) begin
                n_state = S_OUT;
            end
            S_OUT:     if (!r_oval) begin
                n_state = S_IDLE;
            end
            default:   n_state = S_IDLE;
        endcase
    end

    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_aging   <= 1'b1;
            r_max     <= 5'd16;
            r_fill    <= '0;
            r_next_id <= '0;
            r_added   <= '0;
            r_expired <= '0;
            r_oval    <= 1'b0;
            r_rd_ok   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_ENABLE_AGING: r_aging <= i_cfg_data[0];
                    REG_MAX_ENTRIES:  r_max   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_oval && !i_stall)
                r_oval <= 1'b0;

            // read pointer advances in passes; r_rd_ok follows in the next cycle
            r_rd_ok <= pass_rd && !at_end;
            if (pass_rd && !at_end)
                r_ptr <= r_ptr + 1'b1;

            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_mode <= i_mode; r_delta <= i_delta_ms; r_cat <= i_category;
                    r_dur <= i_duration_ms; r_preq <= i_priority_req;
                    r_target <= i_target_id;
                    r_ptr <= '0; r_found <= 1'b0; r_low <= i_priority_req;
                    r_best <= '0; r_status <= 1'b0; r_nid <= '0;
                    r_ccnt <= '0; r_top <= '0; r_drop <= 1'b0;
                end
                S_SCAN: if (r_rd_ok && scan_hit) begin
                    r_found <= 1'b1;
                    r_best  <= r_rd_idx;
                    r_low   <= r_rd.prio;
                end
                S_DECIDE: begin
                    r_wr  <= '0;
                    unique case (r_mode)
                        MODE_ADD: if (r_fill >= limit) begin
                            r_drop <= r_found;
                            if (!r_found)
                                r_status <= 1'b1;
                        end
                        MODE_REMOVE: begin
                            r_drop <= r_found;
                            r_status <= !r_found;
                        end
                        MODE_TICK:  if (!r_aging) begin
                            r_mode <= MODE_QUERY;
                        end
                        default: ;
                    endcase
                    // no rewrite needed unless something changes
                    if (!(r_mode == MODE_TICK && r_aging) &&
                        !(r_mode == MODE_REMOVE && r_found) &&
                        !(r_mode == MODE_ADD && r_fill >= limit && r_found))
                        r_ptr <= r_fill;
                    else
                        r_ptr <= '0;
                end
                S_COMPACT: begin
                    if (r_rd_ok) begin
                        if (mem_we)
                            r_wr <= r_wr + 1'b1;
                        if (r_mode == MODE_TICK && expire)
                            r_expired <= r_expired + 32'd1;
                    end
                    if (at_end && !r_rd_ok && r_ptr == r_fill && r_ptr != '0 &&
                        (r_mode == MODE_TICK || r_drop))
                        r_fill <= mem_we ? r_wr + 1'b1 : r_wr;
                    else if (at_end && !r_rd_ok && (r_mode == MODE_TICK || r_drop))
                        r_fill <= r_wr;
                end
                S_APPEND: begin
                    r_ptr <= '0;
                    if (r_mode == MODE_ADD && !r_status && r_fill < DEPTH_C) begin
                        r_fill    <= r_fill + 1'b1;
                        r_nid     <= r_next_id;
                        r_next_id <= r_next_id + 16'd1;
                        r_added   <= r_added + 32'd1;
                    end else if (r_mode == MODE_ADD) begin
                        r_status <= 1'b1;
                    end
                end
                S_STATS: if (r_rd_ok) begin
                    if (r_rd.cat == r_cat)
                        r_ccnt <= r_ccnt + 5'd1;
                    if (r_rd.prio > r_top)
                        r_top <= r_rd.prio;
                end else if (at_end) begin
                    r_oval <= 1'b1;
                end
                S_OUT: ;
                default: ;
            endcase
        end
    end

    assign o_valid          = r_oval;
    assign o_status         = r_status;
    assign o_new_id         = r_status ? 16'd0 : r_nid;
    assign o_entry_count    = 5'(r_fill);
    assign o_category_count = r_ccnt;
    assign o_has_entries    = (r_fill != '0);
    assign o_top_priority   = r_top;
    assign o_added_total    = r_added;
    assign o_expired_total  = r_expired;
endmodule
